### design/bagt_pkg.sv
package bagt_pkg;

    localparam int BIAS_DEPTH_DEF    = 4096;
    localparam int TANH_SEGMENTS_DEF = 64;

    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 12;
    localparam int POS_W   = 12;
    localparam int CC_W    = 13;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ACT  = 1'b1;

    localparam logic [CC_W-1:0] CC_RESET = 13'd4096;

    localparam logic [15:0] CUBE_C_Q20  = 16'd46887;
    localparam logic [15:0] GELU_K_Q16  = 16'd52290;
    localparam logic [19:0] Z_LIMIT_Q12 = 20'd16384;
    localparam logic [15:0] ONE_Q15     = 16'd32768;

endpackage

### design/bagt_in_if.sv
interface bagt_in_if import bagt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]         bias_slot;
    logic                      last_element;

    modport source (output valid, req_type, value, bias_slot, last_element, input ready);
    modport sink   (input valid, req_type, value, bias_slot, last_element, output ready);
endinterface

### design/bagt_out_if.sv
interface bagt_out_if import bagt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] gelu_out;
    logic                      clipped;

    modport source (output valid, gelu_out, clipped, input ready);
    modport sink   (input valid, gelu_out, clipped, output ready);
endinterface

### design/bagt_cfg_if.sv
interface bagt_cfg_if import bagt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CC_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/bias_add_gelu_tanh_core.sv
// Bias add followed by tanh-form GELU on signed Q4.12 words.
// i_in carries load words (req_type 0: value goes to bias slot bias_slot) and
// activation words (req_type 1: one result on o_out). i_cfg writes the channel
// count; the channel position picks the bias word, wraps at the count and
// returns to 0 after a word marked last_element.
// A load word leaves i_in.ready high. After an activation word is accepted,
// i_in.ready stays low, and its result does not show on o_out, until it leaves
// the final step; the tanh table steps are skipped when |z| >= 4 saturates tanh.
// The steps come from the single 25x17 multiplier: up to seven products in turn.
// o_out is a registered stage: a new word is accepted while a result waits.
// When the receiver stalls, a second result holds in the final step until
// the output register frees.
// Reset clears the channel position, the channel count (to 4096) and the
// output valid; the bias store is not cleared and must be loaded before use.
// i_in and i_cfg are not ready while reset is held.
module bias_add_gelu_tanh_core import bagt_pkg::*; #(
    parameter int BIAS_DEPTH    = BIAS_DEPTH_DEF,
    parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bagt_in_if.sink     i_in,
    bagt_out_if.source  o_out,
    bagt_cfg_if.sink    i_cfg
);

    localparam int AW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int IW = $clog2(TANH_SEGMENTS + 1);
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef logic [15:0] t_knots [TANH_SEGMENTS+1];

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD, ST_SQ, ST_CUBE, ST_LIN, ST_SCALE,
        ST_SEG, ST_KNOT, ST_INTERP, ST_FIN
    } t_state;

    // shift-subtract quotient of non-negative operands, elaboration only
    function automatic longint f_udiv(longint num, longint den);
        longint unsigned q, rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_knots f_build_knots();
        t_knots r;
        longint term, sum, num, numer;
        for (int k = 0; k <= TANH_SEGMENTS; k++) begin
            num  = 8 * k;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int n = 1; n < 80; n++) begin
                term = f_udiv(term * num, longint'(TANH_SEGMENTS * n));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) sum = 0;
            if (sum > ONE_Q30) sum = ONE_Q30;
            numer = ((ONE_Q30 - sum) << 15) + ((ONE_Q30 + sum) >> 1);
            r[k] = 16'(f_udiv(numer, ONE_Q30 + sum));
        end
        return r;
    endfunction

    localparam t_knots KNOTS = f_build_knots();

    t_state              r_state;
    logic [POS_W-1:0]    r_pos;
    logic [CC_W-1:0]     r_cc;
    logic                r_out_valid;
    logic signed [15:0]  r_gelu;
    logic                r_clip;

    logic [15:0]         r_bias_mem [BIAS_DEPTH];
    logic [15:0]         r_rd;
    logic                r_bias_ok;
    logic signed [15:0]  r_x;
    logic signed [16:0]  r_y;
    logic [16:0]         r_a;
    logic [24:0]         r_ma;
    logic [16:0]         r_mb;
    logic [IW-1:0]       r_idx;
    logic [13:0]         r_frac;
    logic [15:0]         r_lo;

    logic                w_in_acc;
    logic [SW-1:0]       w_wslot;
    logic [SW-1:0]       w_rslot;
    logic                w_slot_ok;
    logic                w_pos_ok;
    logic [POS_W-1:0]    w_next_pos;
    logic [CC_W-1:0]     w_limit;
    logic [41:0]         w_prod;
    logic [41:0]         w_rnd12;
    logic [41:0]         w_rnd14;
    logic [41:0]         w_rnd16;
    logic [41:0]         w_rnd20;
    logic signed [16:0]  w_y;
    logic [16:0]         w_a;
    logic [19:0]         w_u;
    logic [19:0]         w_z;
    logic [15:0]         w_t;
    logic [15:0]         w_knot_lo;
    logic [15:0]         w_knot_hi;
    logic [33:0]         w_sum;
    logic signed [17:0]  w_res;
    logic                w_out_free;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_wslot    = SW'(i_in.bias_slot);
    assign w_rslot    = SW'(r_pos);
    assign w_slot_ok  = 17'(i_in.bias_slot) < 17'(BIAS_DEPTH);
    assign w_pos_ok   = 17'(r_pos) < 17'(BIAS_DEPTH);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_limit    = (r_cc == '0) ? CC_W'(1) : r_cc;
        w_next_pos = r_pos + POS_W'(1);
        if ({1'b0, w_next_pos} >= w_limit || i_in.last_element) begin
            w_next_pos = '0;
        end
    end

    assign w_prod  = 42'(r_ma) * 42'(r_mb);
    assign w_rnd12 = w_prod + 42'd2048;
    assign w_rnd14 = w_prod + 42'd8192;
    assign w_rnd16 = w_prod + 42'd32768;
    assign w_rnd20 = w_prod + 42'd524288;

    assign w_y = 17'(r_x) + (r_bias_ok ? 17'($signed(r_rd)) : 17'sd0);
    assign w_a = w_y[16] ? 17'(-w_y) : 17'(w_y);
    assign w_u = 20'(r_a) + w_rnd20[39:20];
    assign w_z = w_rnd16[35:16];
    assign w_t = r_lo + w_rnd14[29:14];

    assign w_knot_lo = KNOTS[r_idx];
    assign w_knot_hi = KNOTS[r_idx + IW'(1)];

    assign w_sum = {{2{r_y[16]}}, r_y, 15'd0} + {1'b0, w_prod[32:0]} + 34'd32768;
    assign w_res = $signed(w_sum[33:16]);

    assign i_in.ready     = (r_state == ST_IDLE) && i_rst_n;
    assign i_cfg.ready    = i_rst_n;
    assign o_out.valid    = r_out_valid;
    assign o_out.gelu_out = r_gelu;
    assign o_out.clipped  = r_clip;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.req_type == REQ_LOAD && w_slot_ok) begin
            r_bias_mem[w_wslot[AW-1:0]] <= i_in.value;
        end
        if (w_in_acc) begin
            r_rd <= r_bias_mem[w_rslot[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cc        <= CC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cc <= i_cfg.data;
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_in.req_type == REQ_ACT) begin
                        r_x       <= i_in.value;
                        r_bias_ok <= w_pos_ok;
                        r_pos     <= w_next_pos;
                        r_state   <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_y     <= w_y;
                    r_a     <= w_a;
                    r_ma    <= 25'(w_a);
                    r_mb    <= w_a;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_ma    <= 25'(w_rnd12[32:12]);
                    r_mb    <= r_a;
                    r_state <= ST_CUBE;
                end
                ST_CUBE: begin
                    r_ma    <= w_rnd12[36:12];
                    r_mb    <= 17'(CUBE_C_Q20);
                    r_state <= ST_LIN;
                end
                ST_LIN: begin
                    r_ma    <= 25'(w_u);
                    r_mb    <= 17'(GELU_K_Q16);
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    if (w_z >= Z_LIMIT_Q12) begin
                        r_ma    <= 25'(r_a);
                        r_mb    <= 17'(ONE_Q15);
                        r_state <= ST_FIN;
                    end else begin
                        r_ma    <= 25'(w_z);
                        r_mb    <= 17'(TANH_SEGMENTS);
                        r_state <= ST_SEG;
                    end
                end
                ST_SEG: begin
                    r_idx   <= IW'(w_prod[41:14]);
                    r_frac  <= w_prod[13:0];
                    r_state <= ST_KNOT;
                end
                ST_KNOT: begin
                    if (w_knot_hi < w_knot_lo) begin
                        r_ma    <= 25'(r_a);
                        r_mb    <= 17'(w_knot_lo);
                        r_state <= ST_FIN;
                    end else begin
                        r_lo    <= w_knot_lo;
                        r_ma    <= 25'(w_knot_hi - w_knot_lo);
                        r_mb    <= 17'(r_frac);
                        r_state <= ST_INTERP;
                    end
                end
                ST_INTERP: begin
                    r_ma    <= 25'(r_a);
                    r_mb    <= 17'(w_t);
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (w_res > 18'sd32767) begin
                            r_gelu <= 16'sh7FFF;
                            r_clip <= 1'b1;
                        end else if (w_res < -18'sd32768) begin
                            r_gelu <= -16'sh8000;
                            r_clip <= 1'b1;
                        end else begin
                            r_gelu <= 16'(w_res);
                            r_clip <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/bias_add_gelu_tanh_core_tb.sv
`timescale 1ns / 100ps

module bias_add_gelu_tanh_core_tb;
    import bagt_pkg::*;

    typedef struct {
        logic                      req;
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         slot;
        logic                      last;
    } stream_word_t;

    typedef struct {
        logic signed [VALUE_W-1:0] gelu;
        logic                      clipped;
    } gelu_word_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bagt_in_if  in_if ();
    bagt_out_if out_if ();
    bagt_cfg_if cfg_if ();

    bias_add_gelu_tanh_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [VALUE_W-1:0] bias_mem [BIAS_DEPTH_DEF];
    logic [POS_W-1:0]          cur_pos = '0;
    logic [CC_W-1:0]           chan_count = CC_RESET;
    longint unsigned           tanh_knots [TANH_SEGMENTS_DEF+1];

    // stimulus-side shadow of the channel walk
    logic [POS_W-1:0] gen_pos = '0;
    logic [CC_W-1:0]  gen_cc = CC_RESET;
    bit               slot_loaded [BIAS_DEPTH_DEF];

    stream_word_t words_to_send [$];
    gelu_word_t   pending_results [$];
    stream_word_t bus_word;
    gelu_word_t   head_result;

    int send_gap   = 0;
    int stall_left = 0;
    int mismatches = 0;
    bit no_idle    = 1'b0;

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic longint exp_neg_q30(longint num, longint den);
        longint term, sum, n;
        term = 64'sd1 << 30;
        sum  = term;
        n    = 1;
        while (n < 80 && term != 0) begin
            term = (term * num) / (den * n);
            if (n[0])
                sum -= term;
            else
                sum += term;
            n++;
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 << 30))
            sum = 64'sd1 << 30;
        return sum;
    endfunction

    function automatic void build_tanh_knots();
        longint unsigned e, one, numer;
        one = 64'd1 << 30;
        for (int k = 0; k <= TANH_SEGMENTS_DEF; k++) begin
            e = exp_neg_q30(8 * k, TANH_SEGMENTS_DEF);
            numer = ((one - e) << 15) + ((one + e) >> 1);
            tanh_knots[k] = numer / (one + e);
        end
    endfunction

    function automatic gelu_word_t gelu_of_sum(logic signed [VALUE_W:0] y);
        longint          ys, prod, acc;
        longint unsigned a, a2, a3, u, z, t, pos, idx, frac, lo, hi;
        gelu_word_t      r;
        ys = y;
        a  = (ys < 0) ? -ys : ys;
        a2 = (a * a + 2048) >> 12;
        a3 = (a2 * a + 2048) >> 12;
        u  = a + ((a3 * CUBE_C_Q20 + (64'd1 << 19)) >> 20);
        z  = (u * GELU_K_Q16 + 32768) >> 16;
        if (z >= Z_LIMIT_Q12) begin
            t = ONE_Q15;
        end else begin
            pos  = z * TANH_SEGMENTS_DEF;
            idx  = pos >> 14;
            frac = pos & 64'h3fff;
            lo   = tanh_knots[idx];
            hi   = tanh_knots[idx+1];
            t    = (hi < lo) ? lo : lo + (((hi - lo) * frac + 8192) >> 14);
        end
        prod = a * t;
        acc  = (ys * 32768 + prod + 32768) >>> 16;
        r.clipped = 1'b0;
        if (acc > 32767) begin
            acc = 32767;
            r.clipped = 1'b1;
        end else if (acc < -32768) begin
            acc = -32768;
            r.clipped = 1'b1;
        end
        r.gelu = acc[VALUE_W-1:0];
        return r;
    endfunction

    function automatic logic [POS_W-1:0] next_channel(logic [POS_W-1:0] p, logic [CC_W-1:0] cc,
                                                     logic last);
        logic [POS_W-1:0] n;
        logic [CC_W-1:0]  lim;
        lim = (cc == 0) ? CC_W'(1) : cc;
        n   = p + 1'b1;
        if (n >= lim || last)
            n = '0;
        return n;
    endfunction

    task automatic apply_word(stream_word_t w);
        logic signed [VALUE_W:0] y;
        if (w.req == REQ_LOAD) begin
            bias_mem[w.slot] = w.value;
        end else begin
            y = w.value + bias_mem[cur_pos];
            pending_results.push_back(gelu_of_sum(y));
            cur_pos = next_channel(cur_pos, chan_count, w.last);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 32768) - 16384;
            default: return $urandom_range(0, 8192) - 4096;
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_bias();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 8192) - 4096;
    endfunction

    task automatic push_load(logic [SLOT_W-1:0] slot, logic signed [VALUE_W-1:0] v);
        stream_word_t w;
        w.req   = REQ_LOAD;
        w.value = v;
        w.slot  = slot;
        w.last  = $urandom_range(0, 1);
        words_to_send.push_back(w);
        slot_loaded[slot] = 1'b1;
    endtask

    // loads the bias slot first if the walk reaches one never written
    task automatic push_sample(logic signed [VALUE_W-1:0] v, logic last);
        stream_word_t w;
        if (!slot_loaded[gen_pos])
            push_load(gen_pos, rand_bias());
        w.req   = REQ_ACT;
        w.value = v;
        w.slot  = $urandom;
        w.last  = last;
        words_to_send.push_back(w);
        gen_pos = next_channel(gen_pos, gen_cc, last);
    endtask

    task automatic wait_sent();
        do @(negedge i_clk); while (words_to_send.size() != 0 || in_if.valid);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || in_if.valid || pending_results.size() != 0);
    endtask

    task automatic run_phase(logic [CC_W-1:0] cc, int n_items, int last_pct, int load_pct,
                             bit quiet);
        wait_idle();
        repeat (12) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cc;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        chan_count = cc;
        gen_cc     = cc;
        no_idle    = quiet;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < load_pct)
                push_load($urandom_range(0, BIAS_DEPTH_DEF - 1), rand_bias());
            else
                push_sample(rand_sample(), $urandom_range(0, 99) < last_pct);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                apply_word(bus_word);
                if (!no_idle && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    in_if.valid <= 1'b0;
                    send_gap--;
                end else if (words_to_send.size() != 0) begin
                    bus_word = words_to_send.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.req_type     <= bus_word.req;
                    in_if.value        <= bus_word.value;
                    in_if.bias_slot    <= bus_word.slot;
                    in_if.last_element <= bus_word.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word gelu_out=%0d clipped=%0b",
                                              out_if.gelu_out, out_if.clipped));
                end else begin
                    head_result = pending_results.pop_front();
                    if (out_if.gelu_out !== head_result.gelu)
                        report_mismatch($sformatf("gelu_out %0d, want %0d",
                                                  out_if.gelu_out, head_result.gelu));
                    if (out_if.clipped !== head_result.clipped)
                        report_mismatch($sformatf("clipped %0b, want %0b (gelu_out %0d)",
                                                  out_if.clipped, head_result.clipped,
                                                  head_result.gelu));
                end
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int spins;
        in_if.valid        = 1'b0;
        in_if.req_type     = REQ_LOAD;
        in_if.value        = '0;
        in_if.bias_slot    = '0;
        in_if.last_element = 1'b0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        build_tanh_knots();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, saturation, last_element, tanh knee
        push_load(0, 0);
        push_load(1, 32767);
        push_load(2, -32768);
        push_load(3, 4096);
        push_load(BIAS_DEPTH_DEF - 1, -1);
        push_sample(0, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(-32768, 1'b1);
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b1);
        push_sample(13700, 1'b1);
        push_sample(-13700, 1'b1);
        push_sample(13720, 1'b1);
        push_sample(4096, 1'b1);
        push_sample(-4096, 1'b1);

        run_phase(1, 80, 10, 20, 1'b0);
        run_phase(0, 60, 10, 20, 1'b0);
        run_phase(5, 80, 15, 20, 1'b0);
        run_phase(CC_RESET, 80, 2, 15, 1'b0);
        run_phase(3, 80, 10, 20, 1'b0);
        // channel count above the 12-bit position range
        run_phase(8191, 60, 0, 0, 1'b0);
        run_phase(4095, 60, 5, 20, 1'b0);
        run_phase($urandom_range(6, 64), 120, 8, 20, 1'b1);

        wait_sent();
        spins = 0;
        while (pending_results.size() != 0 && spins < 4000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
